@@ hw/rtl/afrf_pkg.sv @@
// Package for the audio frame ring FIFO: sizes, opcodes, beat structs and
// the command and status structs between controller and datapath.
// No dependencies.
package afrf_pkg;

    localparam int DEPTH_FRAMES = 1024;
    localparam int MAX_CHANNELS = 8;
    localparam int SAMPLE_BITS  = 32;

    localparam int ADDR_W   = $clog2(DEPTH_FRAMES);
    localparam int PTR_W    = ADDR_W + 1;
    localparam int CNT_W    = 11;
    localparam int AMT_W    = 16;
    localparam int CH_CNT_W = 4;
    localparam int FRAME_W  = MAX_CHANNELS * SAMPLE_BITS;

    localparam logic [CH_CNT_W-1:0] CH_CNT_RESET = CH_CNT_W'(2);
    localparam logic [CH_CNT_W-1:0] CH_CNT_MAX   = CH_CNT_W'(MAX_CHANNELS);
    localparam logic [PTR_W-1:0]    PTR_DEPTH    = PTR_W'(DEPTH_FRAMES);

    typedef enum logic [2:0] {
        OP_WRITE = 3'd0,
        OP_READ  = 3'd1,
        OP_PEEK  = 3'd2,
        OP_SKIP  = 3'd3,
        OP_CLEAR = 3'd4
    } t_opcode;

    typedef struct packed {
        logic [2:0]  opcode;
        logic [15:0] amount;
        logic [31:0] sample_0;
        logic [31:0] sample_1;
        logic [31:0] sample_2;
        logic [31:0] sample_3;
        logic [31:0] sample_4;
        logic [31:0] sample_5;
        logic [31:0] sample_6;
        logic [31:0] sample_7;
    } t_in_beat;

    typedef struct packed {
        logic        frame_valid;
        logic [10:0] frames_moved;
        logic [10:0] available_frames;
        logic [10:0] free_frames;
        logic [31:0] out_sample_0;
        logic [31:0] out_sample_1;
        logic [31:0] out_sample_2;
        logic [31:0] out_sample_3;
        logic [31:0] out_sample_4;
        logic [31:0] out_sample_5;
        logic [31:0] out_sample_6;
        logic [31:0] out_sample_7;
    } t_out_beat;

    typedef struct packed {
        logic latch_in;
        logic exec;
        logic load_out;
    } t_dp_cmd;

    typedef struct packed {
        logic out_free;
    } t_dp_status;

endpackage

@@ hw/rtl/afrf_ctrl.sv @@
// Controller of the audio frame ring FIFO: sequences accept, execute and
// result load for one beat at a time. Depends on afrf_pkg.
module afrf_ctrl import afrf_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    output logic       o_in_stall,
    input  t_dp_status i_status,
    output t_dp_cmd    o_cmd
);

    typedef enum logic [2:0] {
        S_IDLE = 3'b001,
        S_EXEC = 3'b010,
        S_DONE = 3'b100
    } t_state;

    t_state r_state;
    t_state n_state;
    logic   w_accept;

    assign o_in_stall = (r_state != S_IDLE);
    assign w_accept   = i_in_valid && !o_in_stall;

    always_comb begin
        n_state        = r_state;
        o_cmd.latch_in = 1'b0;
        o_cmd.exec     = 1'b0;
        o_cmd.load_out = 1'b0;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.latch_in = 1'b1;
                    n_state        = S_EXEC;
                end
            end
            S_EXEC: begin
                o_cmd.exec = 1'b1;
                n_state    = S_DONE;
            end
            S_DONE: begin
                if (i_status.out_free) begin
                    o_cmd.load_out = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    a_accept_exec: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept |=> (r_state == S_EXEC))
        else $error("accepted beat did not enter execute");

    a_exec_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_EXEC) |=> (r_state == S_DONE))
        else $error("execute did not advance to done");

    a_load_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.load_out |-> i_status.out_free)
        else $error("result loaded over a waiting beat");

endmodule

@@ hw/rtl/afrf_dpath.sv @@
// Datapath of the audio frame ring FIFO: frame memory, head and tail
// pointers, channel count register and result register. Depends on afrf_pkg.
module afrf_dpath import afrf_pkg::*; (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  t_dp_cmd             i_cmd,
    output t_dp_status          o_status,
    input  t_in_beat            i_in_beat,
    input  logic                i_cfg_we,
    input  logic [CH_CNT_W-1:0] i_cfg_data,
    output logic                o_out_valid,
    input  logic                i_out_stall,
    output t_out_beat           o_out_beat
);

    logic [FRAME_W-1:0] r_mem [DEPTH_FRAMES];
    logic [FRAME_W-1:0] r_rd_data;

    t_in_beat            r_in;
    logic [PTR_W-1:0]    r_head;
    logic [PTR_W-1:0]    r_tail;
    logic [CH_CNT_W-1:0] r_ch_cnt;
    logic                r_hit;
    logic [CNT_W-1:0]    r_moved;
    logic                r_out_valid;
    t_out_beat           r_out;

    logic [PTR_W-1:0]    n_head;
    logic [PTR_W-1:0]    n_tail;
    logic                n_hit;
    logic [CNT_W-1:0]    n_moved;

    logic [PTR_W-1:0]    w_used;
    logic [PTR_W-1:0]    w_used_after;
    logic                w_full;
    logic                w_we;
    logic [ADDR_W-1:0]   w_rd_addr;
    logic [CH_CNT_W-1:0] w_act;
    logic [AMT_W-1:0]    w_used_ext;
    logic [MAX_CHANNELS-1:0][SAMPLE_BITS-1:0] w_wr_lanes;
    logic [MAX_CHANNELS-1:0][SAMPLE_BITS-1:0] w_in_lanes;
    logic [MAX_CHANNELS-1:0][SAMPLE_BITS-1:0] w_rd_lanes;

    assign w_used       = r_tail - r_head;
    assign w_used_ext   = AMT_W'(w_used);
    assign w_full       = (w_used == PTR_DEPTH);
    assign w_act        = (r_ch_cnt > CH_CNT_MAX) ? CH_CNT_MAX : r_ch_cnt;
    assign w_used_after = r_tail - r_head;

    assign w_in_lanes[0] = r_in.sample_0;
    assign w_in_lanes[1] = r_in.sample_1;
    assign w_in_lanes[2] = r_in.sample_2;
    assign w_in_lanes[3] = r_in.sample_3;
    assign w_in_lanes[4] = r_in.sample_4;
    assign w_in_lanes[5] = r_in.sample_5;
    assign w_in_lanes[6] = r_in.sample_6;
    assign w_in_lanes[7] = r_in.sample_7;

    always_comb begin
        for (int ch = 0; ch < MAX_CHANNELS; ch++) begin
            w_wr_lanes[ch] = (CH_CNT_W'(ch) < w_act) ? w_in_lanes[ch] : '0;
            w_rd_lanes[ch] = (r_hit && (CH_CNT_W'(ch) < w_act))
                           ? r_rd_data[ch*SAMPLE_BITS +: SAMPLE_BITS] : '0;
        end
    end

    always_comb begin
        n_head    = r_head;
        n_tail    = r_tail;
        n_hit     = 1'b0;
        n_moved   = '0;
        w_we      = 1'b0;
        w_rd_addr = r_head[ADDR_W-1:0];
        case (r_in.opcode)
            OP_WRITE: begin
                if (!w_full) begin
                    w_we    = 1'b1;
                    n_tail  = r_tail + PTR_W'(1);
                    n_moved = CNT_W'(1);
                end
            end
            OP_READ: begin
                if (w_used != '0) begin
                    n_hit   = 1'b1;
                    n_head  = r_head + PTR_W'(1);
                    n_moved = CNT_W'(1);
                end
            end
            OP_PEEK: begin
                w_rd_addr = ADDR_W'(r_head + r_in.amount[PTR_W-1:0]);
                if (r_in.amount < w_used_ext) begin
                    n_hit   = 1'b1;
                    n_moved = CNT_W'(1);
                end
            end
            OP_SKIP: begin
                if (r_in.amount < w_used_ext) begin
                    n_moved = CNT_W'(r_in.amount[PTR_W-1:0]);
                end else begin
                    n_moved = CNT_W'(w_used);
                end
                n_head = r_head + PTR_W'(n_moved);
            end
            OP_CLEAR: begin
                n_head = '0;
                n_tail = '0;
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.exec && w_we) begin
            r_mem[r_tail[ADDR_W-1:0]] <= w_wr_lanes;
        end
        if (i_cmd.exec) begin
            r_rd_data <= r_mem[w_rd_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.latch_in) begin
            r_in <= i_in_beat;
        end
        if (i_cmd.exec) begin
            r_hit   <= n_hit;
            r_moved <= n_moved;
        end
        if (i_cmd.load_out) begin
            r_out.frame_valid      <= r_hit || (r_in.opcode == OP_WRITE && r_moved != '0);
            r_out.frames_moved     <= r_moved;
            r_out.available_frames <= CNT_W'(w_used_after);
            r_out.free_frames      <= CNT_W'(PTR_DEPTH - w_used_after);
            r_out.out_sample_0     <= w_rd_lanes[0];
            r_out.out_sample_1     <= w_rd_lanes[1];
            r_out.out_sample_2     <= w_rd_lanes[2];
            r_out.out_sample_3     <= w_rd_lanes[3];
            r_out.out_sample_4     <= w_rd_lanes[4];
            r_out.out_sample_5     <= w_rd_lanes[5];
            r_out.out_sample_6     <= w_rd_lanes[6];
            r_out.out_sample_7     <= w_rd_lanes[7];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head      <= '0;
            r_tail      <= '0;
            r_ch_cnt    <= CH_CNT_RESET;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cmd.exec) begin
                r_head <= n_head;
                r_tail <= n_tail;
            end
            if (i_cfg_we) begin
                r_ch_cnt <= i_cfg_data;
            end
            if (i_cmd.load_out) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_status.out_free = !r_out_valid || !i_out_stall;
    assign o_out_valid       = r_out_valid;
    assign o_out_beat        = r_out;

    a_used_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_used <= PTR_DEPTH)
        else $error("stored frame count above depth");

    a_counts_sum: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |->
            (PTR_W'(r_out.available_frames) + PTR_W'(r_out.free_frames) == PTR_DEPTH))
        else $error("available and free counts do not add up to depth");

    a_valid_moved: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out.frame_valid) |-> (r_out.frames_moved == CNT_W'(1)))
        else $error("valid frame without exactly one frame moved");

endmodule

@@ hw/rtl/audio_frame_ring_fifo_top.sv @@
// Top level of the audio frame ring FIFO: joins controller and datapath.
// Depends on afrf_pkg, afrf_ctrl and afrf_dpath.
//
//   channel   handshake                  payload
//   input     i_in_valid / o_in_stall    i_in_beat  (t_in_beat)
//   output    o_out_valid / i_out_stall  o_out_beat (t_out_beat)
//   config    i_cfg_we                   i_cfg_data (channel_count)
//
// Each beat passes through accept, execute (one memory access and
// pointer update) and result load into the output register.
// A new beat is accepted once the previous result is loaded; a stalled
// result holds in the output register while the next beat is accepted.
// Synchronous active-low reset clears pointers, sets channel_count to 2;
// the frame memory is not cleared, and only written slots are ever read.
module audio_frame_ring_fifo_top import afrf_pkg::*; (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_stall,
    input  t_in_beat            i_in_beat,
    output logic                o_out_valid,
    input  logic                i_out_stall,
    output t_out_beat           o_out_beat,
    input  logic                i_cfg_we,
    input  logic [CH_CNT_W-1:0] i_cfg_data
);

    t_dp_cmd    w_cmd;
    t_dp_status w_status;

    afrf_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_status   (w_status),
        .o_cmd      (w_cmd)
    );

    afrf_dpath u_dpath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (w_cmd),
        .o_status    (w_status),
        .i_in_beat   (i_in_beat),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_data  (i_cfg_data),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_beat  (o_out_beat)
    );

endmodule

@@ tb/sv/tb_audio_frame_ring_fifo_top.sv @@
// Testbench for audio_frame_ring_fifo_top: directed, channel-count, fill/wrap
// and random traffic tests, checked against an in-bench FIFO predictor.
// Depends on afrf_pkg and the audio_frame_ring_fifo_top RTL.
module tb_audio_frame_ring_fifo_top;
    import afrf_pkg::*;

    logic                clk       = 1'b0;
    logic                rst_n     = 1'b0;
    logic                in_valid  = 1'b0;
    logic                in_stall;
    t_in_beat            in_beat   = '0;
    logic                out_valid;
    logic                out_stall = 1'b0;
    t_out_beat           out_beat;
    logic                cfg_we    = 1'b0;
    logic [CH_CNT_W-1:0] cfg_data  = CH_CNT_RESET;

    logic [SAMPLE_BITS-1:0] frame_mem [DEPTH_FRAMES][MAX_CHANNELS];
    logic [PTR_W-1:0]       head_ptr;
    logic [PTR_W-1:0]       tail_ptr;
    logic [CH_CNT_W-1:0]    chan_cfg;
    t_out_beat              expected_results[$];
    t_out_beat              want;

    int errors       = 0;
    int beats_sent   = 0;
    int results_seen = 0;
    int burst_left   = 0;
    int stall_cycle  = 0;
    int stall_run    = 0;

    always #5 clk = ~clk;

    audio_frame_ring_fifo_top dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_stall  (in_stall),
        .i_in_beat   (in_beat),
        .o_out_valid (out_valid),
        .i_out_stall (out_stall),
        .o_out_beat  (out_beat),
        .i_cfg_we    (cfg_we),
        .i_cfg_data  (cfg_data)
    );

    function automatic logic [SAMPLE_BITS-1:0] in_lane(t_in_beat b, int k);
        return b[(MAX_CHANNELS-1-k)*SAMPLE_BITS +: SAMPLE_BITS];
    endfunction

    function automatic logic [SAMPLE_BITS-1:0] out_lane(t_out_beat r, int k);
        return r[(MAX_CHANNELS-1-k)*SAMPLE_BITS +: SAMPLE_BITS];
    endfunction

    function automatic logic [PTR_W-1:0] stored_frames();
        return tail_ptr - head_ptr;
    endfunction

    function automatic t_out_beat predict_frame_result(t_in_beat b);
        t_out_beat        r;
        int               lanes;
        logic [PTR_W-1:0] used;
        logic [PTR_W-1:0] moved;
        logic [PTR_W-1:0] slot_ptr;
        logic             do_fetch;
        r        = '0;
        lanes    = (chan_cfg > CH_CNT_MAX) ? MAX_CHANNELS : int'(chan_cfg);
        used     = stored_frames();
        do_fetch = 1'b0;
        slot_ptr = head_ptr;
        case (b.opcode)
            OP_WRITE: begin
                if (used < PTR_DEPTH) begin
                    for (int k = 0; k < MAX_CHANNELS; k++)
                        frame_mem[tail_ptr[ADDR_W-1:0]][k] = (k < lanes) ? in_lane(b, k) : '0;
                    tail_ptr       = tail_ptr + 1'b1;
                    r.frame_valid  = 1'b1;
                    r.frames_moved = CNT_W'(1);
                end
            end
            OP_READ: begin
                if (used != 0) begin
                    do_fetch       = 1'b1;
                    head_ptr       = head_ptr + 1'b1;
                    r.frame_valid  = 1'b1;
                    r.frames_moved = CNT_W'(1);
                end
            end
            OP_PEEK: begin
                if (b.amount < used) begin
                    do_fetch       = 1'b1;
                    slot_ptr       = head_ptr + PTR_W'(b.amount);
                    r.frame_valid  = 1'b1;
                    r.frames_moved = CNT_W'(1);
                end
            end
            OP_SKIP: begin
                moved          = (b.amount < used) ? PTR_W'(b.amount) : used;
                head_ptr       = head_ptr + moved;
                r.frames_moved = moved;
            end
            OP_CLEAR: begin
                head_ptr = '0;
                tail_ptr = '0;
            end
            default: ;
        endcase
        if (do_fetch)
            for (int k = 0; k < lanes; k++)
                r[(MAX_CHANNELS-1-k)*SAMPLE_BITS +: SAMPLE_BITS] =
                    frame_mem[slot_ptr[ADDR_W-1:0]][k];
        r.available_frames = stored_frames();
        r.free_frames      = PTR_DEPTH - stored_frames();
        return r;
    endfunction

    function automatic t_in_beat make_beat(logic [2:0] op, logic [AMT_W-1:0] amt);
        t_in_beat b;
        int       pick;
        b.opcode = op;
        b.amount = amt;
        for (int k = 0; k < MAX_CHANNELS; k++) begin
            pick = $urandom_range(0, 15);
            b[(MAX_CHANNELS-1-k)*SAMPLE_BITS +: SAMPLE_BITS] =
                (pick == 0) ? '0 : (pick == 1) ? '1 : $urandom;
        end
        return b;
    endfunction

    task automatic check_field(string name, logic [31:0] exp_val, logic [31:0] act_val);
        if (exp_val !== act_val) begin
            $display("%0t: %s mismatch: expected %h, actual %h", $time, name, exp_val, act_val);
            errors++;
        end
    endtask

    task automatic send_beat(input t_in_beat b);
        int gap;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 24);
            gap        = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            if (gap > 0) begin
                in_valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
        burst_left--;
        in_valid <= 1'b1;
        in_beat  <= b;
        do @(posedge clk); while (in_stall);
        expected_results.push_back(predict_frame_result(b));
        beats_sent++;
    endtask

    task automatic wait_idle();
        in_valid <= 1'b0;
        while (expected_results.size() != 0) @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic set_channels(input logic [CH_CNT_W-1:0] value);
        wait_idle();
        cfg_we   <= 1'b1;
        cfg_data <= value;
        @(posedge clk);
        cfg_we   <= 1'b0;
        chan_cfg  = value;
    endtask

    task automatic test_directed_ops();
        t_in_beat b;
        send_beat(make_beat(OP_READ, 16'd0));
        send_beat(make_beat(OP_PEEK, 16'd0));
        send_beat(make_beat(OP_SKIP, 16'd5));
        b = make_beat(OP_WRITE, 16'hFFFF);
        b[FRAME_W-1:0] = '1;
        send_beat(b);
        b = make_beat(OP_WRITE, 16'd0);
        b[FRAME_W-1:0] = '0;
        send_beat(b);
        b = make_beat(OP_WRITE, 16'h5A5A);
        b[FRAME_W-1:0] = {MAX_CHANNELS{32'hA5A5_5A5A}};
        send_beat(b);
        send_beat(make_beat(OP_PEEK, 16'd0));
        send_beat(make_beat(OP_PEEK, 16'd2));
        send_beat(make_beat(OP_PEEK, 16'd3));
        send_beat(make_beat(OP_PEEK, 16'hFFFF));
        send_beat(make_beat(OP_READ, 16'hFFFF));
        send_beat(make_beat(OP_SKIP, 16'd0));
        send_beat(make_beat(OP_SKIP, 16'hFFFF));
        send_beat(make_beat(3'd5, 16'd1));
        send_beat(make_beat(3'd6, 16'hFFFF));
        send_beat(make_beat(3'd7, 16'd0));
        send_beat(make_beat(OP_WRITE, 16'd0));
        send_beat(make_beat(OP_CLEAR, 16'hFFFF));
        send_beat(make_beat(OP_READ, 16'd0));
        send_beat(make_beat(OP_PEEK, 16'd0));
        send_beat(make_beat(OP_WRITE, 16'd0));
        send_beat(make_beat(OP_READ, 16'd0));
    endtask

    task automatic test_channel_counts();
        logic [CH_CNT_W-1:0] counts [6] = '{4'd1, 4'd8, 4'd0, 4'd15, 4'd9, 4'd3};
        foreach (counts[i]) begin
            set_channels(counts[i]);
            send_beat(make_beat(OP_WRITE, 16'd0));
            send_beat(make_beat(OP_WRITE, 16'd0));
            send_beat(make_beat(OP_PEEK, 16'd1));
            send_beat(make_beat(OP_READ, 16'd0));
            send_beat(make_beat(OP_READ, 16'd0));
        end
        // stored with all lanes, then read back narrower
        set_channels(CH_CNT_MAX);
        repeat (3) send_beat(make_beat(OP_WRITE, 16'd0));
        set_channels(4'd1);
        send_beat(make_beat(OP_READ, 16'd0));
        set_channels(4'd0);
        send_beat(make_beat(OP_PEEK, 16'd0));
        send_beat(make_beat(OP_READ, 16'd0));
        set_channels(4'd5);
        send_beat(make_beat(OP_READ, 16'd0));
    endtask

    task automatic test_fill_and_wrap();
        set_channels(CH_CNT_MAX);
        send_beat(make_beat(OP_CLEAR, 16'd0));
        repeat (DEPTH_FRAMES + 3) send_beat(make_beat(OP_WRITE, AMT_W'($urandom)));
        send_beat(make_beat(OP_PEEK, 16'(DEPTH_FRAMES - 1)));
        send_beat(make_beat(OP_PEEK, 16'(DEPTH_FRAMES)));
        send_beat(make_beat(OP_PEEK, 16'd0));
        send_beat(make_beat(OP_SKIP, 16'd1000));
        repeat (40) send_beat(make_beat(OP_WRITE, 16'd0));
        repeat (30) send_beat(make_beat(OP_READ, 16'd0));
        send_beat(make_beat(OP_PEEK, 16'd500));
        send_beat(make_beat(OP_SKIP, 16'hFFFF));
        send_beat(make_beat(OP_READ, 16'd0));
        repeat (40) begin
            send_beat(make_beat(OP_WRITE, 16'd0));
            send_beat(make_beat(OP_READ, 16'd0));
        end
    endtask

    task automatic test_random_traffic(input int n_items);
        int                 sent;
        int                 phase_len;
        int                 wr_weight;
        int                 pick;
        logic [2:0]         op;
        logic [AMT_W-1:0]   amt;
        logic [PTR_W-1:0]   used;
        logic [CH_CNT_W-1:0] count;
        sent = 0;
        while (sent < n_items) begin
            pick  = $urandom_range(0, 5);
            count = (pick == 0) ? 4'd1 : (pick == 1) ? CH_CNT_MAX :
                    (pick == 2) ? 4'd0 : (pick == 3) ? 4'd15 : 4'($urandom_range(0, 15));
            set_channels(count);
            phase_len = $urandom_range(150, 300);
            wr_weight = $urandom_range(15, 90);
            for (int i = 0; i < phase_len && sent < n_items; i++) begin
                used = stored_frames();
                amt  = AMT_W'($urandom);
                if ($urandom_range(0, 99) < wr_weight) begin
                    op = OP_WRITE;
                end else begin
                    pick = $urandom_range(0, 99);
                    if (pick < 42)
                        op = OP_READ;
                    else if (pick < 77)
                        op = OP_PEEK;
                    else if (pick < 92)
                        op = OP_SKIP;
                    else if (pick < 95)
                        op = OP_CLEAR;
                    else
                        op = 3'($urandom_range(5, 7));
                end
                if (op == OP_PEEK && $urandom_range(0, 4) != 0)
                    amt = 16'($urandom_range(0, int'(used) + 1));
                if (op == OP_SKIP && $urandom_range(0, 4) != 0)
                    amt = 16'($urandom_range(0, 4));
                send_beat(make_beat(op, amt));
                sent++;
                if (i == phase_len / 2 || $urandom_range(0, 199) == 0)
                    wait_idle();
            end
        end
    endtask

    always @(posedge clk) begin
        stall_cycle++;
        if (!rst_n) begin
            out_stall <= 1'b0;
        end else begin
            case ((stall_cycle / 300) % 4)
                0: out_stall <= 1'b0;
                1: out_stall <= ($urandom_range(0, 3) == 0);
                2: begin
                    if (stall_run > 0)
                        stall_run--;
                    else if ($urandom_range(0, 2) == 0)
                        stall_run = $urandom_range(1, 12);
                    out_stall <= (stall_run > 0);
                end
                default: out_stall <= (stall_cycle % 3 == 0);
            endcase
        end
    end

    always @(posedge clk) begin
        if (rst_n && out_valid && !out_stall) begin
            if (expected_results.size() == 0) begin
                $display("%0t: result beat with nothing expected: expected none, actual %h",
                         $time, out_beat);
                errors++;
            end else begin
                want = expected_results.pop_front();
                results_seen++;
                check_field("frame_valid", 32'(want.frame_valid), 32'(out_beat.frame_valid));
                check_field("frames_moved", 32'(want.frames_moved), 32'(out_beat.frames_moved));
                check_field("available_frames", 32'(want.available_frames),
                            32'(out_beat.available_frames));
                check_field("free_frames", 32'(want.free_frames), 32'(out_beat.free_frames));
                for (int k = 0; k < MAX_CHANNELS; k++)
                    check_field($sformatf("out_sample_%0d", k), out_lane(want, k),
                                out_lane(out_beat, k));
            end
        end
    end

    initial begin
        #5_000_000;
        $display("audio_frame_ring_fifo_top test failed");
        $finish;
    end

    initial begin
        head_ptr = '0;
        tail_ptr = '0;
        chan_cfg = CH_CNT_RESET;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_directed_ops();
        test_channel_counts();
        test_fill_and_wrap();
        test_random_traffic(250);
        wait_idle();
        repeat (10) @(posedge clk);
        if (expected_results.size() != 0) begin
            $display("%0t: %0d expected results never arrived", $time, expected_results.size());
            errors++;
        end
        $display("Sent %0d beats and checked %0d results: all opcodes, unused opcodes,",
                 beats_sent, results_seen);
        $display("zero, in-range and oversized channel counts, full, empty and wrapped FIFO;");
        $display("%0d mismatches.", errors);
        if (errors == 0)
            $display("audio_frame_ring_fifo_top test passed");
        else
            $display("audio_frame_ring_fifo_top test failed");
        $finish;
    end

endmodule
